// ===== rtl/cc20_pkg.sv =====
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int NumWords     = 16;
    localparam int DoubleRounds = 10;

    typedef logic [7:0]                 t_byte;
    typedef logic [31:0]                t_word;
    typedef logic [63:0]                t_cfg_data;
    typedef logic [2:0]                 t_cfg_index;
    typedef logic [NumWords-1:0][31:0]  t_block;

    // "expand 32-byte k"
    localparam t_word Sigma0 = 32'h6170_7865;
    localparam t_word Sigma1 = 32'h3320_646e;
    localparam t_word Sigma2 = 32'h7962_2d32;
    localparam t_word Sigma3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        REG_KEY_A,
        REG_KEY_B,
        REG_KEY_C,
        REG_KEY_D,
        REG_NONCE_LO,
        REG_NONCE_HI,
        REG_CTR_START
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_GEN,
        S_XOR
    } t_top_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_QR,
        B_DIAG_IN,
        B_DIAG_OUT,
        B_FINAL
    } t_blk_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_blk_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_blk_stat;

endpackage

// ===== rtl/cc20_if.sv =====
`timescale 1ns / 1ps

interface cc20_in_if import cc20_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_in;
    logic  start_message;

    modport source (output valid, output data_in, output start_message, input ready);
    modport sink   (input valid, input data_in, input start_message, output ready);
endinterface

interface cc20_out_if import cc20_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

interface cc20_cfg_if import cc20_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cc20_blk.sv =====
`timescale 1ns / 1ps

module cc20_blk import cc20_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_blk_ctl  i_ctl,
    input  t_block    i_init,
    output t_blk_stat o_stat,
    output t_byte     o_ks_byte
);

    t_blk_state r_state, n_state;
    t_block     r_w, n_w;
    logic [1:0] r_step, n_step;
    logic [1:0] r_col, n_col;
    logic       r_diag, n_diag;
    logic [3:0] r_dr, n_dr;
    logic [3:0] r_fin, n_fin;

    t_word  add_p, add_q, add_sum, mix_in, mix_out;
    t_block qr_w;
    logic   done;

    function automatic t_word rotl_step(input t_word v, input logic [1:0] step);
        t_word r;
        case (step)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

    // Words are kept as four rows of four; the quarter-round always works on
    // column 0, so rows are rotated to bring the next column or diagonal there.
    function automatic t_block row_rot(input t_block w, input logic diag_in,
                                       input logic diag_out);
        t_block     f;
        logic [1:0] amt;
        logic [1:0] src;
        f = w;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                amt = diag_in ? 2'(r) : (diag_out ? 2'(4 - r) : 2'd1);
                src = 2'(j) + amt;
                f[r*4+j] = w[{2'(r), src}];
            end
        end
        return f;
    endfunction

    // shared add / xor / rotate unit
    always_comb begin
        if (r_state == B_FINAL) begin
            add_p = r_w[0];
            add_q = i_init[r_fin];
        end else if (r_step[0]) begin
            add_p = r_w[8];
            add_q = r_w[12];
        end else begin
            add_p = r_w[0];
            add_q = r_w[4];
        end
        add_sum = add_p + add_q;
        mix_in  = (r_step[0] ? r_w[4] : r_w[12]) ^ add_sum;
        mix_out = rotl_step(mix_in, r_step);

        qr_w = r_w;
        if (r_step[0]) begin
            qr_w[8] = add_sum;
            qr_w[4] = mix_out;
        end else begin
            qr_w[0]  = add_sum;
            qr_w[12] = mix_out;
        end
    end

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_step  = r_step;
        n_col   = r_col;
        n_diag  = r_diag;
        n_dr    = r_dr;
        n_fin   = r_fin;
        done    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_ctl.load) begin
                    n_w     = i_init;
                    n_step  = '0;
                    n_col   = '0;
                    n_diag  = 1'b0;
                    n_dr    = '0;
                    n_state = B_QR;
                end else if (i_ctl.shift) begin
                    n_w = r_w >> 8;
                end
            end
            B_QR: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_w   = row_rot(qr_w, 1'b0, 1'b0);
                    n_col = r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        n_state = r_diag ? B_DIAG_OUT : B_DIAG_IN;
                    end
                end else begin
                    n_w = qr_w;
                end
            end
            B_DIAG_IN: begin
                n_w     = row_rot(r_w, 1'b1, 1'b0);
                n_diag  = 1'b1;
                n_state = B_QR;
            end
            B_DIAG_OUT: begin
                n_w    = row_rot(r_w, 1'b0, 1'b1);
                n_diag = 1'b0;
                if (r_dr == 4'(DoubleRounds - 1)) begin
                    n_fin   = '0;
                    n_state = B_FINAL;
                end else begin
                    n_dr    = r_dr + 4'd1;
                    n_state = B_QR;
                end
            end
            B_FINAL: begin
                // add input state back, one word a cycle, words shift down
                n_w   = {add_sum, r_w[NumWords-1:1]};
                n_fin = r_fin + 4'd1;
                if (r_fin == 4'(NumWords - 1)) begin
                    done    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
            r_col   <= '0;
            r_diag  <= 1'b0;
            r_dr    <= '0;
            r_fin   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_col   <= n_col;
            r_diag  <= n_diag;
            r_dr    <= n_dr;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_stat.busy = (r_state != B_IDLE);
    assign o_stat.done = done;
    assign o_ks_byte   = r_w[0][7:0];

endmodule

// ===== rtl/chacha20_stream_cipher_core.sv =====
`timescale 1ns / 1ps
// ChaCha20 byte cipher, 96-bit nonce, 32-bit block counter.
// i_in takes one word per byte (data_in, start_message); o_out returns
// data_in XOR the next keystream byte, one word per input word, in order.
// i_cfg writes key, nonce and counter_start by index (always ready); write
// it only while no byte is in flight. Key/nonce are sampled at each new
// block; counter_start is loaded when a byte carries start_message.
// Flow: a byte with keystream on hand goes from acceptance through S_XOR
// to o_out.valid; the next byte is taken only once it has left S_XOR.
// A byte that opens a new 64-byte block (start_message, or the previous
// block used up) first waits for the block: a load state, then one shared
// add/xor/rotate unit runs 4 steps per quarter-round, 8 quarter-rounds plus
// a row-rotate state before and after the diagonals per double round,
// 10 double rounds, a feed-forward add of all 16 words, then the XOR state.
// i_in.ready is high only while no byte is being processed; the output
// register decouples the sides, so a new byte is accepted while the last
// result waits. A stalled o_out holds its word and delays the next result.
// Reset clears the config registers and the block counter to zero and marks
// the keystream used up, so a first byte without start_message generates block 0.

module chacha20_stream_cipher_core import cc20_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cc20_in_if.sink     i_in,
    cc20_out_if.source  o_out,
    cc20_cfg_if.sink    i_cfg
);

    t_top_state r_state, n_state;
    t_word      r_block_counter, n_block_counter;
    logic [6:0] r_pos, n_pos;
    t_byte      r_data, n_data;
    t_byte      r_out, n_out;
    logic       r_out_valid, n_out_valid;

    t_cfg_data  r_key_a, r_key_b, r_key_c, r_key_d, r_nonce_lo;
    t_word      r_nonce_hi, r_ctr_start;

    t_block     init;
    t_blk_ctl   blk_ctl;
    t_blk_stat  blk_stat;
    t_byte      ks_byte;
    logic       in_acc;
    logic       out_free;

    always_comb begin
        init[0]  = Sigma0;
        init[1]  = Sigma1;
        init[2]  = Sigma2;
        init[3]  = Sigma3;
        init[4]  = r_key_a[31:0];
        init[5]  = r_key_a[63:32];
        init[6]  = r_key_b[31:0];
        init[7]  = r_key_b[63:32];
        init[8]  = r_key_c[31:0];
        init[9]  = r_key_c[63:32];
        init[10] = r_key_d[31:0];
        init[11] = r_key_d[63:32];
        init[12] = r_block_counter;
        init[13] = r_nonce_lo[31:0];
        init[14] = r_nonce_lo[63:32];
        init[15] = r_nonce_hi;
    end

    cc20_blk u_blk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (blk_ctl),
        .i_init    (init),
        .o_stat    (blk_stat),
        .o_ks_byte (ks_byte)
    );

    assign i_cfg.ready    = 1'b1;
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out;

    assign in_acc   = i_in.valid & i_in.ready;
    assign out_free = ~r_out_valid | o_out.ready;

    always_comb begin
        n_state         = r_state;
        n_block_counter = r_block_counter;
        n_pos           = r_pos;
        n_data          = r_data;
        n_out           = r_out;
        n_out_valid     = r_out_valid & ~o_out.ready;
        blk_ctl.load    = 1'b0;
        blk_ctl.shift   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_data = i_in.data_in;
                    if (i_in.start_message) begin
                        n_block_counter = r_ctr_start;
                        n_pos           = 7'd64;
                    end
                    n_state = (i_in.start_message || r_pos[6]) ? S_LOAD : S_XOR;
                end
            end
            S_LOAD: begin
                blk_ctl.load = 1'b1;
                n_state      = S_GEN;
            end
            S_GEN: begin
                if (blk_stat.done) begin
                    n_block_counter = r_block_counter + 32'd1;
                    n_pos           = '0;
                    n_state         = S_XOR;
                end
            end
            S_XOR: begin
                if (out_free) begin
                    n_out         = r_data ^ ks_byte;
                    n_out_valid   = 1'b1;
                    n_pos         = r_pos + 7'd1;
                    blk_ctl.shift = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_block_counter <= '0;
            r_pos           <= 7'd64;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_block_counter <= n_block_counter;
            r_pos           <= n_pos;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a     <= '0;
            r_key_b     <= '0;
            r_key_c     <= '0;
            r_key_d     <= '0;
            r_nonce_lo  <= '0;
            r_nonce_hi  <= '0;
            r_ctr_start <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.index))
                REG_KEY_A:     r_key_a     <= i_cfg.data;
                REG_KEY_B:     r_key_b     <= i_cfg.data;
                REG_KEY_C:     r_key_c     <= i_cfg.data;
                REG_KEY_D:     r_key_d     <= i_cfg.data;
                REG_NONCE_LO:  r_nonce_lo  <= i_cfg.data;
                REG_NONCE_HI:  r_nonce_hi  <= i_cfg.data[31:0];
                REG_CTR_START: r_ctr_start <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    a_done_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_stat.done |-> r_state == S_GEN)
        else $error("keystream block finished outside generation wait");

    a_blk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !blk_stat.busy)
        else $error("block engine busy while accepting bytes");

    a_start_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.start_message |=> r_block_counter == $past(r_ctr_start))
        else $error("message start did not load block counter");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 7'd64)
        else $error("keystream position past end of block");

endmodule
